/* hw/rtl/gdfs_pkg.sv */
// ----------------------------------------------------------------------------
// Graph DFS package
// Shared types and constants of the depth-first search block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 1024;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    ActAdd      = 2'd0,
    ActTraverse = 2'd1,
    ActClear    = 2'd2,
    ActNone     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatRange = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef struct packed {
    action_e    action;
    logic       bad;
    logic [5:0] from_vertex;
    logic [5:0] to_vertex;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StAddRd,
    StAddWr,
    StTrHead,
    StTrEdge,
    StTrEdgeWait,
    StEmit,
    StClear
  } back_state_e;

endpackage

/* hw/rtl/gdfs_front.sv */
// ----------------------------------------------------------------------------
// Graph DFS front end
// Accepts input transfers, checks vertex ranges and queues commands.
// ----------------------------------------------------------------------------
module gdfs_front #(
  parameter int unsigned MaxVertices = gdfs_pkg::MaxVertices
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic [6:0]          vertex_count_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output gdfs_pkg::cmd_t      cmd_o
);

  localparam int unsigned Qd = gdfs_pkg::QueueDepth;

  gdfs_pkg::cmd_t q_q [Qd];
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [6:0]     eff;
  gdfs_pkg::cmd_t cmd;
  logic           push, pop;

  always_comb begin
    eff = vertex_count_i;
    if (eff == 7'd0) eff = 7'd1;
    if (eff > 7'(MaxVertices)) eff = 7'(MaxVertices);
    cmd.action      = gdfs_pkg::action_e'(s_axis_tuser);
    cmd.from_vertex = s_axis_tdata[5:0];
    cmd.to_vertex   = s_axis_tdata[11:6];
    cmd.bad = (((cmd.action == gdfs_pkg::ActAdd) || (cmd.action == gdfs_pkg::ActTraverse)) &&
               ({1'b0, cmd.from_vertex} >= eff)) ||
              ((cmd.action == gdfs_pkg::ActAdd) && ({1'b0, cmd.to_vertex} >= eff));
  end

  assign s_axis_tready = (cnt_q != 2'(Qd));
  assign push  = s_axis_tvalid && s_axis_tready && (cmd.action != gdfs_pkg::ActNone);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop   = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Qd)) else $error("queue overfilled");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(Qd) |-> !push) else $error("push into full queue");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

/* hw/rtl/gdfs_back.sv */
// ----------------------------------------------------------------------------
// Graph DFS back end
// Executes queued commands against the edge memory and runs the traversal.
// ----------------------------------------------------------------------------
module gdfs_back #(
  parameter int unsigned MaxVertices = gdfs_pkg::MaxVertices,
  parameter int unsigned MaxEdges    = gdfs_pkg::MaxEdges
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  gdfs_pkg::cmd_t cmd_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,
  output logic           m_axis_tlast
);

  localparam int unsigned Ew = $clog2(MaxEdges + 1);
  localparam int unsigned Aw = $clog2(MaxEdges);
  localparam int unsigned Vw = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned Dw = $clog2(MaxVertices + 1);
  localparam logic [Ew-1:0] Nil = Ew'(MaxEdges);

  gdfs_pkg::back_state_e st_q, st_d;

  logic [5:0]    etgt_mem [MaxEdges];
  logic [Ew-1:0] enxt_mem [MaxEdges];
  logic [Ew-1:0] head_mem [MaxVertices];
  logic [Ew-1:0] tail_mem [MaxVertices];
  logic [MaxVertices-1:0] hvalid_q;
  logic [MaxVertices-1:0] vis_q;
  logic [Vw-1:0] stk_v_mem [MaxVertices];
  logic [Ew-1:0] stk_c_mem [MaxVertices];

  logic [Ew-1:0] used_q;
  logic [Dw-1:0] depth_q;
  logic [Dw-1:0] count_q;
  logic [Ew-1:0] cur_q;
  logic [Vw-1:0] top_v_q;
  logic [Vw-1:0] pend_q;
  gdfs_pkg::cmd_t cmd_q;
  logic [Ew-1:0] head_rd_q, tail_rd_q;
  logic [5:0]    et_rd_q;
  logic [Ew-1:0] en_rd_q;
  logic [Ew-1:0] sc_rd_q;

  logic          obuf_v_q;
  logic [5:0]    obuf_vx_q;
  logic          obuf_l_q;
  logic [1:0]    obuf_s_q;

  logic          take;
  logic          emit;
  logic [5:0]    emit_vx;
  logic          emit_l;
  gdfs_pkg::status_e emit_s;
  logic          obuf_free;
  logic [Vw-1:0] sv, w;
  logic [Ew-1:0] hd_of_v;

  assign obuf_free   = !obuf_v_q || m_axis_tready;
  assign cmd_ready_o = (st_q == gdfs_pkg::StIdle) && obuf_free;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign sv          = Vw'(cmd_q.from_vertex);
  assign w           = Vw'(et_rd_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      gdfs_pkg::StIdle: begin
        if (take) begin
          case (cmd_i.action)
            gdfs_pkg::ActAdd:      st_d = cmd_i.bad ? gdfs_pkg::StIdle : gdfs_pkg::StAddRd;
            gdfs_pkg::ActTraverse: st_d = cmd_i.bad ? gdfs_pkg::StIdle : gdfs_pkg::StTrHead;
            default:               st_d = gdfs_pkg::StIdle;
          endcase
        end
      end
      gdfs_pkg::StAddRd: st_d = gdfs_pkg::StAddWr;
      gdfs_pkg::StAddWr: if (obuf_free) st_d = gdfs_pkg::StIdle;
      gdfs_pkg::StTrHead: st_d = gdfs_pkg::StEmit;
      gdfs_pkg::StEmit: if (obuf_free) st_d = gdfs_pkg::StTrEdge;
      gdfs_pkg::StTrEdge: begin
        if (cur_q == Nil) begin
          if (depth_q == Dw'(1) && obuf_free) st_d = gdfs_pkg::StIdle;
          else if (depth_q != Dw'(1)) st_d = gdfs_pkg::StClear;
        end else st_d = gdfs_pkg::StTrEdgeWait;
      end
      gdfs_pkg::StTrEdgeWait: begin
        if (!vis_q[w] && depth_q < Dw'(MaxVertices) && count_q < Dw'(MaxVertices))
          st_d = gdfs_pkg::StTrHead;
        else st_d = gdfs_pkg::StTrEdge;
      end
      gdfs_pkg::StClear: st_d = gdfs_pkg::StTrEdge;
      default: st_d = gdfs_pkg::StIdle;
    endcase
  end

  // The emitted visit waits in the pending slot until the next visit or the end.
  always_comb begin
    emit    = 1'b0;
    emit_vx = 6'd0;
    emit_l  = 1'b1;
    emit_s  = gdfs_pkg::StatOk;
    case (st_q)
      gdfs_pkg::StIdle: begin
        if (take && (cmd_i.action != gdfs_pkg::ActTraverse || cmd_i.bad) &&
            !(cmd_i.action == gdfs_pkg::ActAdd && !cmd_i.bad)) begin
          emit   = 1'b1;
          emit_s = cmd_i.bad ? gdfs_pkg::StatRange : gdfs_pkg::StatOk;
        end
      end
      gdfs_pkg::StAddWr: begin
        emit   = obuf_free;
        emit_s = (used_q >= Nil) ? gdfs_pkg::StatFull : gdfs_pkg::StatOk;
      end
      gdfs_pkg::StEmit: begin
        emit    = obuf_free && count_q > Dw'(1);
        emit_vx = 6'(pend_q);
        emit_l  = 1'b0;
      end
      gdfs_pkg::StTrEdge: begin
        if (cur_q == Nil && depth_q == Dw'(1)) begin
          emit    = obuf_free;
          emit_vx = 6'(pend_q);
          emit_l  = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign hd_of_v = hvalid_q[top_v_q] ? head_rd_q : Nil;

  always_ff @(posedge clk_i) begin
    case (st_q)
      gdfs_pkg::StIdle: if (take) cmd_q <= cmd_i;
      gdfs_pkg::StAddRd: begin
        head_rd_q <= head_mem[sv];
        tail_rd_q <= tail_mem[sv];
      end
      gdfs_pkg::StAddWr: begin
        if (obuf_free && used_q < Nil) begin
          etgt_mem[used_q[Aw-1:0]] <= cmd_q.to_vertex;
          enxt_mem[used_q[Aw-1:0]] <= Nil;
          tail_mem[sv] <= used_q;
          if (hvalid_q[sv]) enxt_mem[tail_rd_q[Aw-1:0]] <= used_q;
          else head_mem[sv] <= used_q;
        end
      end
      default: ;
    endcase
    if (st_q == gdfs_pkg::StTrHead || st_q == gdfs_pkg::StClear)
      head_rd_q <= head_mem[top_v_q];
    if (st_q == gdfs_pkg::StTrEdge && cur_q == Nil && depth_q != Dw'(1))
      sc_rd_q <= stk_c_mem[Vw'(depth_q - Dw'(2))];
    if (st_q == gdfs_pkg::StTrEdge && cur_q != Nil) begin
      et_rd_q <= etgt_mem[cur_q[Aw-1:0]];
      en_rd_q <= enxt_mem[cur_q[Aw-1:0]];
    end
    if (st_q == gdfs_pkg::StTrEdgeWait) begin
      stk_c_mem[Vw'(depth_q - Dw'(1))] <= en_rd_q;
      if (!vis_q[w] && depth_q < Dw'(MaxVertices) && count_q < Dw'(MaxVertices))
        stk_v_mem[Vw'(depth_q)] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= gdfs_pkg::StIdle;
      hvalid_q  <= '0;
      vis_q     <= '0;
      used_q    <= '0;
      depth_q   <= '0;
      count_q   <= '0;
      cur_q     <= '0;
      top_v_q   <= '0;
      pend_q    <= '0;
      obuf_v_q  <= 1'b0;
      obuf_vx_q <= '0;
      obuf_l_q  <= 1'b0;
      obuf_s_q  <= '0;
    end else begin
      st_q <= st_d;
      if (emit) begin
        obuf_v_q  <= 1'b1;
        obuf_vx_q <= emit_vx;
        obuf_l_q  <= emit_l;
        obuf_s_q  <= emit_s;
      end else if (m_axis_tready) obuf_v_q <= 1'b0;
      case (st_q)
        gdfs_pkg::StIdle: if (take) begin
          if (cmd_i.action == gdfs_pkg::ActClear) begin
            hvalid_q <= '0;
            used_q   <= '0;
            vis_q    <= '0;
          end
          if (cmd_i.action == gdfs_pkg::ActTraverse) begin
            if (cmd_i.bad) begin
              vis_q <= '0;
            end else begin
              vis_q   <= MaxVertices'(1) << cmd_i.from_vertex;
              top_v_q <= Vw'(cmd_i.from_vertex);
              pend_q  <= Vw'(cmd_i.from_vertex);
              depth_q <= Dw'(1);
              count_q <= Dw'(1);
            end
          end
        end
        gdfs_pkg::StAddWr: if (obuf_free && used_q < Nil) begin
          used_q      <= used_q + Ew'(1);
          hvalid_q[sv] <= 1'b1;
        end
        gdfs_pkg::StEmit: begin
          cur_q <= hd_of_v;
          if (obuf_free) pend_q <= top_v_q;
        end
        gdfs_pkg::StTrEdge: if (cur_q == Nil && depth_q != Dw'(1)) begin
          depth_q <= depth_q - Dw'(1);
        end else if (cur_q == Nil && obuf_free) depth_q <= '0;
        gdfs_pkg::StTrEdgeWait: begin
          cur_q <= en_rd_q;
          if (!vis_q[w] && depth_q < Dw'(MaxVertices) && count_q < Dw'(MaxVertices)) begin
            vis_q[w] <= 1'b1;
            top_v_q  <= w;
            depth_q  <= depth_q + Dw'(1);
            count_q  <= count_q + Dw'(1);
          end
        end
        gdfs_pkg::StClear: begin
          cur_q   <= sc_rd_q;
          top_v_q <= stk_v_mem[Vw'(depth_q - Dw'(1))];
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = obuf_v_q;
  assign m_axis_tdata  = {obuf_s_q, obuf_vx_q};
  assign m_axis_tlast  = obuf_l_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> st_q == gdfs_pkg::StIdle) else $error("busy but ready");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= Dw'(MaxVertices)) else $error("stack overflow");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Nil) else $error("edge count overflow");

endmodule

/* hw/rtl/graph_depth_first_search.sv */
// ----------------------------------------------------------------------------
// Graph depth-first search
// Directed graph store with an iterative depth-first traversal engine.
// ----------------------------------------------------------------------------
// Input transfers on s_axis carry the action in tuser and from_vertex and
// to_vertex in tdata. The front end checks ranges and places each command
// in a two-entry queue; the back end executes it. An edge add passes
// through StAddRd and StAddWr and gives one result; a clear is done on
// acceptance. A traversal gives one result per visited vertex and walks
// the single-port edge memory with StTrEdge and StTrEdgeWait per stored
// edge examined, StTrHead and StEmit per visit and StTrEdge and StClear
// per return to a parent. Each visit is held back until the next one or
// the end of the walk is known, so that the final one can carry tlast.
// Results leave through one output register; when the receiver stalls,
// the back end holds and the queue fills, after which s_axis_tready
// drops. Reset empties the graph at once through valid bits and sets
// vertex_count to 64. The register is written on a cfg_valid_i transfer.
// ----------------------------------------------------------------------------
module graph_depth_first_search #(
  parameter int unsigned MaxVertices = gdfs_pkg::MaxVertices,
  parameter int unsigned MaxEdges    = gdfs_pkg::MaxEdges
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // from_vertex, to_vertex
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // visited_vertex, status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  logic [6:0]     vcount_q;
  logic           cmd_valid, cmd_ready;
  gdfs_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vcount_q <= 7'd64;
    else if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
  end

  gdfs_front #(.MaxVertices(MaxVertices)) u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .vertex_count_i(vcount_q), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_o(cmd)
  );

  gdfs_back #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule
